FILE: design/rtc_pkg.sv
// shared types, constants and fixed-point helpers for the closest-hit ray tracer
package rtc_pkg;

  localparam int WORD_W        = 32;
  localparam int FRAC_BITS     = 16;
  localparam int MAX_TRIANGLES = 256;
  localparam int WORDS_PER_TRI = 12;
  localparam int TRI_W         = $clog2(MAX_TRIANGLES);
  localparam int N_W           = $clog2(MAX_TRIANGLES + 1);
  localparam int CNT_W         = 9;
  localparam int SLOT_W        = 8;
  localparam int SEL_W         = 4;
  localparam int DIST_W        = 31;
  localparam int WGT_W         = 17;
  localparam int IDX_W         = 8;
  localparam int PROD_W        = 2 * WORD_W - FRAC_BITS;
  localparam int ACC_W         = PROD_W + 2;
  localparam int DVD_W         = WORD_W + FRAC_BITS;
  localparam int DIV_LAT       = DVD_W + 2;
  localparam int IN_DATA_W     = 240;
  localparam int OUT_DATA_W    = 176;

  // command codes on the input tuser
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_CAST = 1'b1;

  // configuration register indexes
  localparam logic CFG_FAR_PLANE = 1'b0;
  localparam logic CFG_TRI_COUNT = 1'b1;

  localparam logic [DIST_W-1:0] FAR_RESET = DIST_W'(65536000);

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam word_t WORD_MAX = word_t'({1'b0, {(WORD_W-1){1'b1}}});
  localparam word_t WORD_MIN = word_t'({1'b1, {(WORD_W-1){1'b0}}});
  localparam word_t ONE_Q    = word_t'(1) <<< FRAC_BITS;
  localparam word_t T_MIN    = word_t'(((1 << FRAC_BITS) + 5000) / 10000);

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
  } vec_t;

  typedef struct packed {
    logic             last;
    logic [TRI_W-1:0] idx;
  } meta_t;

  // beat that rides beside the distance divider
  typedef struct packed {
    meta_t m;
    logic  den_ok;
    word_t n1;
    word_t n2;
    vec_t  ab;
    vec_t  ac;
    vec_t  b;
    vec_t  c;
  } mid_t;

  // beat that rides beside the weight dividers
  typedef struct packed {
    meta_t m;
    logic  ok;
    word_t t;
    vec_t  q;
  } late_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_RESULT
  } state_e;

  function automatic word_t sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(WORD_MAX);
    lo = ACC_W'(WORD_MIN);
    if (v > hi) return WORD_MAX;
    if (v < lo) return WORD_MIN;
    return word_t'(v[WORD_W-1:0]);
  endfunction

  // product shifted down with floor rounding
  function automatic prod_t mulq(input word_t a, input word_t b);
    logic signed [2*WORD_W-1:0] p;
    p = a * b;
    return prod_t'(p[2*WORD_W-1:FRAC_BITS]);
  endfunction

  function automatic word_t sub_sat(input word_t a, input word_t b);
    return sat(ACC_W'(a) - ACC_W'(b));
  endfunction

  function automatic vec_t vsub(input vec_t a, input vec_t b);
    vec_t r;
    r.x = sub_sat($signed(a.x), $signed(b.x));
    r.y = sub_sat($signed(a.y), $signed(b.y));
    r.z = sub_sat($signed(a.z), $signed(b.z));
    return r;
  endfunction

  function automatic word_t dot3(input prod_t a, input prod_t b, input prod_t c);
    return sat(ACC_W'(a) + ACC_W'(b) + ACC_W'(c));
  endfunction

  function automatic word_t cross2(input prod_t a, input prod_t b);
    return sat(ACC_W'(a) - ACC_W'(b));
  endfunction

  function automatic word_t addp(input word_t a, input prod_t p);
    return sat(ACC_W'(a) + ACC_W'(p));
  endfunction

endpackage

FILE: design/rtc_ram.sv
// generic single-port-write ram with registered read
module rtc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/rtc_div.sv
// pipelined signed fixed-point divider, one quotient bit per stage, saturating
module rtc_div (
  input  logic          clk_i,
  input  rtc_pkg::word_t num_i,
  input  rtc_pkg::word_t den_i,
  output rtc_pkg::word_t quo_o
);
  import rtc_pkg::*;

  localparam logic [DVD_W-1:0] HALF = DVD_W'(1) << (WORD_W - 1);

  logic [WORD_W-1:0] rem_q [DVD_W+1];
  logic [DVD_W-1:0]  wrk_q [DVD_W+1];
  logic [WORD_W-1:0] dvs_q [DVD_W+1];
  logic              neg_q [DVD_W+1];
  logic [WORD_W-1:0] num_mag;
  logic [WORD_W-1:0] den_mag;
  logic [DVD_W-1:0]  mag;
  word_t             quo_d;
  word_t             quo_q;

  // magnitudes and sign of the quotient
  assign num_mag = num_i[WORD_W-1] ? WORD_W'(-num_i) : WORD_W'(num_i);
  assign den_mag = den_i[WORD_W-1] ? WORD_W'(-den_i) : WORD_W'(den_i);

  always_ff @(posedge clk_i) begin
    rem_q[0] <= '0;
    wrk_q[0] <= {num_mag, {FRAC_BITS{1'b0}}};
    dvs_q[0] <= den_mag;
    neg_q[0] <= num_i[WORD_W-1] ^ den_i[WORD_W-1];
  end

  // restoring steps
  for (genvar s = 1; s <= DVD_W; s++) begin : g_step
    logic [WORD_W:0] sh;
    logic [WORD_W:0] dif;
    logic            ge;
    assign sh  = {rem_q[s-1], wrk_q[s-1][DVD_W-1]};
    assign dif = sh - {1'b0, dvs_q[s-1]};
    assign ge  = sh >= {1'b0, dvs_q[s-1]};
    always_ff @(posedge clk_i) begin
      rem_q[s] <= ge ? dif[WORD_W-1:0] : sh[WORD_W-1:0];
      wrk_q[s] <= {wrk_q[s-1][DVD_W-2:0], ge};
      dvs_q[s] <= dvs_q[s-1];
      neg_q[s] <= neg_q[s-1];
    end
  end

  // sign and saturation
  assign mag = wrk_q[DVD_W];
  always_comb begin
    if (neg_q[DVD_W]) begin
      quo_d = (mag > HALF) ? WORD_MIN : word_t'(-mag[WORD_W-1:0]);
    end else begin
      quo_d = (mag >= HALF) ? WORD_MAX : word_t'(mag[WORD_W-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
  end

  assign quo_o = quo_q;

endmodule

FILE: design/ray_triangle_closest_hit.sv
// closest-hit ray / triangle intersection over a stored triangle list
//
//  channel  | direction | beat contents
//  s_axis   | in        | tuser cmd; tdata load word or ray origin and direction
//  m_axis   | out       | tuser hit; tdata distance, index, weights, hit point
//  cfg      | in        | addr register index, data value (far plane, count)
//
// a load beat writes one word of the triangle store
// a cast walks triangles 0..n-1, one per cycle, through a pipeline of
// 2*(32+FRAC_BITS+2)+11 stages, set by the two 50-stage divider chains; a ray's
// result beat is loaded once its last triangle leaves the pipeline, or without a walk if n is 0
// reset clears control and the count and resets the far plane; the store is not cleared
// the result waits in an output register while the next beat may be accepted
module ray_triangle_closest_hit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [7:0] tri_slot, [11:8] word_sel, [43:12] word_value, [75:44] origin_x,
  // [107:76] origin_y, [139:108] origin_z, [171:140] dir_x, [203:172] dir_y,
  // [235:204] dir_z, rest zero
  input  logic [rtc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [0] cmd
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [30:0] distance, [38:31] tri_index, [55:39] weight_b, [72:56] weight_c,
  // [104:73] point_x, [136:105] point_y, [168:137] point_z, rest zero
  output logic [rtc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // [0] hit
  output logic                             m_axis_tuser,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic                             cfg_addr_i,
  input  logic [rtc_pkg::WORD_W-1:0]       cfg_data_i
);
  import rtc_pkg::*;

  // input fields
  logic [SLOT_W-1:0] in_slot;
  logic [SEL_W-1:0]  in_sel;
  word_t             in_value;
  vec_t              in_org;
  vec_t              in_dir;

  assign in_slot  = s_axis_tdata[7:0];
  assign in_sel   = s_axis_tdata[11:8];
  assign in_value = s_axis_tdata[43:12];
  assign in_org   = '{x: s_axis_tdata[75:44], y: s_axis_tdata[107:76],
                      z: s_axis_tdata[139:108]};
  assign in_dir   = '{x: s_axis_tdata[171:140], y: s_axis_tdata[203:172],
                      z: s_axis_tdata[235:204]};

  // control
  state_e            state_q, state_d;
  logic              in_ready, issue, load_out;
  logic              s_fire, cast_fire, load_fire;
  logic [N_W-1:0]    n_q, n_d, idx_q;
  logic [DIST_W-1:0] far_q;
  logic [CNT_W-1:0]  cnt_q;
  vec_t              org_q, dir_q;

  assign s_fire    = s_axis_tvalid && in_ready;
  assign cast_fire = s_fire && (s_axis_tuser == CMD_CAST);
  assign load_fire = s_fire && (s_axis_tuser == CMD_LOAD);
  assign s_axis_tready = in_ready;
  assign cfg_ready_o   = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      far_q <= FAR_RESET;
      cnt_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        CFG_FAR_PLANE: far_q <= cfg_data_i[DIST_W-1:0];
        CFG_TRI_COUNT: cnt_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_d = (32'(cnt_q) > 32'(MAX_TRIANGLES)) ? N_W'(MAX_TRIANGLES) : N_W'(cnt_q);

  // tail of the pipeline
  logic  tail_v;
  late_t tail;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cast_fire) state_d = (n_d == '0) ? ST_RESULT : ST_ISSUE;
      end
      ST_ISSUE: begin
        if (idx_q == n_q - N_W'(1)) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (tail_v && tail.m.last) state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!m_axis_tvalid || m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      ST_IDLE:   in_ready = 1'b1;
      ST_ISSUE:  issue = 1'b1;
      ST_DRAIN:  ;
      ST_RESULT: load_out = !m_axis_tvalid || m_axis_tready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cast_fire) begin
        idx_q <= '0;
        n_q   <= n_d;
      end else if (issue) begin
        idx_q <= idx_q + N_W'(1);
      end
    end
  end

  // ray held for the whole walk
  always_ff @(posedge clk_i) begin
    if (cast_fire) begin
      org_q <= in_org;
      dir_q <= in_dir;
    end
  end

  // triangle store: one bank per word of a triangle
  word_t rd [WORDS_PER_TRI];
  logic  slot_ok;
  assign slot_ok = 32'(in_slot) < 32'(MAX_TRIANGLES);

  for (genvar k = 0; k < WORDS_PER_TRI; k++) begin : g_bank
    rtc_ram #(
      .WIDTH(WORD_W),
      .DEPTH(MAX_TRIANGLES)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (load_fire && slot_ok && (in_sel == SEL_W'(k))),
      .waddr_i(TRI_W'(in_slot)),
      .wdata_i(in_value),
      .re_i   (issue),
      .raddr_i(idx_q[TRI_W-1:0]),
      .rdata_o(rd[k])
    );
  end

  // stage valids and tags
  logic  v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q;
  meta_t m0_q, m1_q, m2_q, m3_q, m4_q;

  vec_t ta, tb, tc, tn;
  assign ta = '{x: rd[0], y: rd[1], z: rd[2]};
  assign tb = '{x: rd[3], y: rd[4], z: rd[5]};
  assign tc = '{x: rd[6], y: rd[7], z: rd[8]};
  assign tn = '{x: rd[9], y: rd[10], z: rd[11]};

  // s1: edge and origin differences
  vec_t  s1_da, s1_e1, s1_e2, s1_nm, s1_b, s1_c;
  // s2: products for plane terms and edge crosses
  prod_t s2_pd [3];
  prod_t s2_pn [3];
  prod_t s2_ab [6];
  prod_t s2_ac [6];
  vec_t  s2_e1, s2_e2, s2_b, s2_c;
  // s3: denominator, numerator, cross vectors
  word_t s3_den, s3_num;
  vec_t  s3_ab, s3_ac, s3_e1, s3_e2, s3_b, s3_c;
  // s4: products for weight denominators
  prod_t s4_p1 [3];
  prod_t s4_p2 [3];
  word_t s4_den, s4_num;
  vec_t  s4_ab, s4_ac, s4_b, s4_c;
  // s5: into the distance divider
  word_t s5_den, s5_num;
  mid_t  s5_mid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v0_q <= issue;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m0_q <= '{last: (idx_q == n_q - N_W'(1)), idx: idx_q[TRI_W-1:0]};
    // s1
    m1_q  <= m0_q;
    s1_da <= vsub(ta, org_q);
    s1_e1 <= vsub(tb, ta);
    s1_e2 <= vsub(tc, ta);
    s1_nm <= tn;
    s1_b  <= tb;
    s1_c  <= tc;
    // s2
    m2_q     <= m1_q;
    s2_pd[0] <= mulq(dir_q.x, s1_nm.x);
    s2_pd[1] <= mulq(dir_q.y, s1_nm.y);
    s2_pd[2] <= mulq(dir_q.z, s1_nm.z);
    s2_pn[0] <= mulq(s1_da.x, s1_nm.x);
    s2_pn[1] <= mulq(s1_da.y, s1_nm.y);
    s2_pn[2] <= mulq(s1_da.z, s1_nm.z);
    s2_ab[0] <= mulq(s1_e1.y, s1_nm.z);
    s2_ab[1] <= mulq(s1_e1.z, s1_nm.y);
    s2_ab[2] <= mulq(s1_e1.z, s1_nm.x);
    s2_ab[3] <= mulq(s1_e1.x, s1_nm.z);
    s2_ab[4] <= mulq(s1_e1.x, s1_nm.y);
    s2_ab[5] <= mulq(s1_e1.y, s1_nm.x);
    s2_ac[0] <= mulq(s1_e2.y, s1_nm.z);
    s2_ac[1] <= mulq(s1_e2.z, s1_nm.y);
    s2_ac[2] <= mulq(s1_e2.z, s1_nm.x);
    s2_ac[3] <= mulq(s1_e2.x, s1_nm.z);
    s2_ac[4] <= mulq(s1_e2.x, s1_nm.y);
    s2_ac[5] <= mulq(s1_e2.y, s1_nm.x);
    s2_e1    <= s1_e1;
    s2_e2    <= s1_e2;
    s2_b     <= s1_b;
    s2_c     <= s1_c;
    // s3
    m3_q     <= m2_q;
    s3_den   <= dot3(s2_pd[0], s2_pd[1], s2_pd[2]);
    s3_num   <= dot3(s2_pn[0], s2_pn[1], s2_pn[2]);
    s3_ab    <= '{x: cross2(s2_ab[0], s2_ab[1]), y: cross2(s2_ab[2], s2_ab[3]),
                  z: cross2(s2_ab[4], s2_ab[5])};
    s3_ac    <= '{x: cross2(s2_ac[0], s2_ac[1]), y: cross2(s2_ac[2], s2_ac[3]),
                  z: cross2(s2_ac[4], s2_ac[5])};
    s3_e1    <= s2_e1;
    s3_e2    <= s2_e2;
    s3_b     <= s2_b;
    s3_c     <= s2_c;
    // s4
    m4_q     <= m3_q;
    s4_p1[0] <= mulq(s3_e2.x, s3_ab.x);
    s4_p1[1] <= mulq(s3_e2.y, s3_ab.y);
    s4_p1[2] <= mulq(s3_e2.z, s3_ab.z);
    s4_p2[0] <= mulq(s3_e1.x, s3_ac.x);
    s4_p2[1] <= mulq(s3_e1.y, s3_ac.y);
    s4_p2[2] <= mulq(s3_e1.z, s3_ac.z);
    s4_den   <= s3_den;
    s4_num   <= s3_num;
    s4_ab    <= s3_ab;
    s4_ac    <= s3_ac;
    s4_b     <= s3_b;
    s4_c     <= s3_c;
    // s5
    s5_den        <= s4_den;
    s5_num        <= s4_num;
    s5_mid.m      <= m4_q;
    s5_mid.den_ok <= (s4_den != '0);
    s5_mid.n1     <= dot3(s4_p1[0], s4_p1[1], s4_p1[2]);
    s5_mid.n2     <= dot3(s4_p2[0], s4_p2[1], s4_p2[2]);
    s5_mid.ab     <= s4_ab;
    s5_mid.ac     <= s4_ac;
    s5_mid.b      <= s4_b;
    s5_mid.c      <= s4_c;
  end

  // distance divider and its side line
  word_t t_quo;
  logic  dl1_v_q [DIV_LAT];
  mid_t  dl1_q   [DIV_LAT];

  rtc_div u_div_t (
    .clk_i(clk_i),
    .num_i(s5_num),
    .den_i(s5_den),
    .quo_o(t_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_LAT; k++) dl1_v_q[k] <= 1'b0;
    end else begin
      dl1_v_q[0] <= v5_q;
      for (int k = 1; k < DIV_LAT; k++) dl1_v_q[k] <= dl1_v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    dl1_q[0] <= s5_mid;
    for (int k = 1; k < DIV_LAT; k++) dl1_q[k] <= dl1_q[k-1];
  end

  // s6..s10: hit point and weight numerators
  mid_t  s6_mid, s7_mid, s8_mid, s9_mid;
  word_t s6_t, s7_t, s8_t, s9_t;
  prod_t s6_p [3];
  vec_t  s7_q, s8_q, s9_q;
  vec_t  s8_qb, s8_qc;
  prod_t s9_pc [3];
  prod_t s9_pb [3];
  word_t s10_numc, s10_numb, s10_n1, s10_n2;
  late_t s10_late;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
    end else begin
      v6_q  <= dl1_v_q[DIV_LAT-1];
      v7_q  <= v6_q;
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v10_q <= v9_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // s6
    s6_mid  <= dl1_q[DIV_LAT-1];
    s6_t    <= t_quo;
    s6_p[0] <= mulq(dir_q.x, t_quo);
    s6_p[1] <= mulq(dir_q.y, t_quo);
    s6_p[2] <= mulq(dir_q.z, t_quo);
    // s7
    s7_mid  <= s6_mid;
    s7_t    <= s6_t;
    s7_q    <= '{x: addp(org_q.x, s6_p[0]), y: addp(org_q.y, s6_p[1]),
                 z: addp(org_q.z, s6_p[2])};
    // s8
    s8_mid  <= s7_mid;
    s8_t    <= s7_t;
    s8_q    <= s7_q;
    s8_qb   <= vsub(s7_q, s7_mid.b);
    s8_qc   <= vsub(s7_q, s7_mid.c);
    // s9
    s9_mid   <= s8_mid;
    s9_t     <= s8_t;
    s9_q     <= s8_q;
    s9_pc[0] <= mulq(s8_qb.x, s8_mid.ab.x);
    s9_pc[1] <= mulq(s8_qb.y, s8_mid.ab.y);
    s9_pc[2] <= mulq(s8_qb.z, s8_mid.ab.z);
    s9_pb[0] <= mulq(s8_qc.x, s8_mid.ac.x);
    s9_pb[1] <= mulq(s8_qc.y, s8_mid.ac.y);
    s9_pb[2] <= mulq(s8_qc.z, s8_mid.ac.z);
    // s10
    s10_numc    <= dot3(s9_pc[0], s9_pc[1], s9_pc[2]);
    s10_numb    <= dot3(s9_pb[0], s9_pb[1], s9_pb[2]);
    s10_n1      <= s9_mid.n1;
    s10_n2      <= s9_mid.n2;
    s10_late.m  <= s9_mid.m;
    s10_late.ok <= s9_mid.den_ok && (s9_mid.n1 != '0) && (s9_mid.n2 != '0);
    s10_late.t  <= s9_t;
    s10_late.q  <= s9_q;
  end

  // weight dividers and their side line
  word_t wc_quo, wb_quo;
  logic  dl2_v_q [DIV_LAT];
  late_t dl2_q   [DIV_LAT];

  rtc_div u_div_wc (
    .clk_i(clk_i),
    .num_i(s10_numc),
    .den_i(s10_n1),
    .quo_o(wc_quo)
  );

  rtc_div u_div_wb (
    .clk_i(clk_i),
    .num_i(s10_numb),
    .den_i(s10_n2),
    .quo_o(wb_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_LAT; k++) dl2_v_q[k] <= 1'b0;
    end else begin
      dl2_v_q[0] <= v10_q;
      for (int k = 1; k < DIV_LAT; k++) dl2_v_q[k] <= dl2_v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    dl2_q[0] <= s10_late;
    for (int k = 1; k < DIV_LAT; k++) dl2_q[k] <= dl2_q[k-1];
  end

  assign tail_v = dl2_v_q[DIV_LAT-1];
  assign tail   = dl2_q[DIV_LAT-1];

  // running closest hit
  logic [DIST_W-1:0] closest_q;
  logic              found_q;
  logic [TRI_W-1:0]  best_i_q;
  word_t             best_b_q, best_c_q;
  vec_t              pt_q;

  // range and weight tests, in triangle order
  logic                    take;
  logic signed [WORD_W:0]  wsum;
  word_t                   tt;
  assign tt   = $signed(tail.t);
  assign wsum = (WORD_W+1)'(wb_quo) + (WORD_W+1)'(wc_quo);
  assign take = tail_v && tail.ok && (tt >= T_MIN) && (tt <= $signed({1'b0, closest_q}))
             && !wb_quo[WORD_W-1] && !wc_quo[WORD_W-1]
             && (wb_quo <= ONE_Q) && (wc_quo <= ONE_Q)
             && (wsum <= (WORD_W+1)'(ONE_Q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      closest_q <= FAR_RESET;
      found_q   <= 1'b0;
    end else if (cast_fire) begin
      closest_q <= far_q;
      found_q   <= 1'b0;
    end else if (take) begin
      closest_q <= tt[DIST_W-1:0];
      found_q   <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cast_fire) begin
      best_i_q <= '0;
      best_b_q <= '0;
      best_c_q <= '0;
      pt_q     <= '0;
    end else if (take) begin
      best_i_q <= tail.m.idx;
      best_b_q <= wb_quo;
      best_c_q <= wc_quo;
      pt_q     <= tail.q;
    end
  end

  // output register
  logic                  out_v_q;
  logic                  out_hit_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (load_out) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_hit_q  <= found_q;
      out_data_q <= {7'b0, pt_q.z, pt_q.y, pt_q.x, best_c_q[WGT_W-1:0],
                     best_b_q[WGT_W-1:0], IDX_W'(best_i_q), closest_q};
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_hit_q;
  assign m_axis_tdata  = out_data_q;

endmodule
